// ===== rtl/sld_pkg.sv =====
// Shared types and codes for the sync/length-prefixed byte deframer.
package sld_pkg;

  // Event codes carried on the result channel
  localparam logic [2:0] EV_NONE     = 3'd0;
  localparam logic [2:0] EV_BYTE     = 3'd1;
  localparam logic [2:0] EV_LAST     = 3'd2;
  localparam logic [2:0] EV_EMPTY    = 3'd3;
  localparam logic [2:0] EV_OVERSIZE = 3'd4;

  // Command codes
  localparam logic CMD_RX    = 1'b0;
  localparam logic CMD_RESET = 1'b1;

  // Configuration register indexes
  localparam logic [1:0] REG_SYNC_FIRST    = 2'd0;
  localparam logic [1:0] REG_SYNC_SECOND   = 2'd1;
  localparam logic [1:0] REG_PAYLOAD_LIMIT = 2'd2;

  localparam logic [15:0] PAYLOAD_LIMIT_RST = 16'd1024;

  // One result beat
  typedef struct packed {
    logic [2:0]  event_res;
    logic [7:0]  frame_type;
    logic [15:0] frame_length;
    logic [7:0]  data_byte;
    logic [15:0] byte_offset;
    logic        busy_res;
  } res_t;

endpackage

// ===== rtl/sync_length_deframer.sv =====
// An accepted beat's result is registered at out_, or in the skid if out_ is stalled.
// Throughput: one byte per cycle while in_stall is low; frame state updates at accept.
// An output register plus a one-entry skid stage decouple the sides: in_stall is the
// skid-full flag, so input keeps flowing while one result waits on a stalled output.
// Reset (rst_n low, synchronous): hunting first sync, all latches zero, registers at
// defaults (sync bytes 0, payload limit 1024), output and skid empty.
module sync_length_deframer
  import sld_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  // input channel
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_command,
  input  logic [7:0]  in_rx_byte,
  // result channel
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  out_event_res,
  output logic [7:0]  out_frame_type,
  output logic [15:0] out_frame_length,
  output logic [7:0]  out_data_byte,
  output logic [15:0] out_byte_offset,
  output logic        out_busy_res,
  // configuration write channel
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_wdata
);

  // Frame phase; the unused code falls into the discard arm.
  typedef enum logic [2:0] {
    PH_HUNT1   = 3'd0,
    PH_HUNT2   = 3'd1,
    PH_TYPE    = 3'd2,
    PH_LEN_LO  = 3'd3,
    PH_LEN_HI  = 3'd4,
    PH_PAYLOAD = 3'd5,
    PH_DISCARD = 3'd6
  } phase_t;

  logic [7:0]  sync_first_r;
  logic [7:0]  sync_second_r;
  logic [15:0] payload_limit_r;

  phase_t      phase_r, phase_nxt;
  logic [7:0]  kind_r, kind_nxt;
  logic [15:0] length_r, length_nxt;
  logic [15:0] count_r, count_nxt;
  logic [15:0] discard_r, discard_nxt;

  res_t        res_nxt;
  res_t        out_r;
  res_t        skid_r;
  logic        out_valid_r;
  logic        skid_valid_r;

  logic        in_accept;
  logic        out_take;
  logic [15:0] len_full;
  logic [15:0] count_inc;
  logic [15:0] discard_dec;

  assign cfg_ready = 1'b1;
  assign in_stall  = skid_valid_r;
  assign in_accept = in_valid && !skid_valid_r;
  assign out_take  = out_valid_r && !out_stall;

  assign len_full    = {in_rx_byte, length_r[7:0]};
  assign count_inc   = count_r + 16'd1;
  assign discard_dec = (discard_r != 16'd0) ? (discard_r - 16'd1) : 16'd0;

  // Next frame state and the result for the beat being offered
  always_comb begin
    phase_nxt   = phase_r;
    kind_nxt    = kind_r;
    length_nxt  = length_r;
    count_nxt   = count_r;
    discard_nxt = discard_r;
    res_nxt     = '0;
    res_nxt.event_res = EV_NONE;

    if (in_command == CMD_RESET) begin
      phase_nxt   = PH_HUNT1;
      length_nxt  = '0;
      count_nxt   = '0;
      discard_nxt = '0;
    end else begin
      case (phase_r)
        PH_HUNT1: begin
          if (in_rx_byte == sync_first_r) phase_nxt = PH_HUNT2;
        end
        PH_HUNT2: begin
          // a repeated first sync byte keeps the partial match
          if (in_rx_byte == sync_second_r)     phase_nxt = PH_TYPE;
          else if (in_rx_byte == sync_first_r) phase_nxt = PH_HUNT2;
          else                                 phase_nxt = PH_HUNT1;
        end
        PH_TYPE: begin
          kind_nxt  = in_rx_byte;
          phase_nxt = PH_LEN_LO;
        end
        PH_LEN_LO: begin
          length_nxt = {8'd0, in_rx_byte};
          phase_nxt  = PH_LEN_HI;
        end
        PH_LEN_HI: begin
          length_nxt = len_full;
          count_nxt  = '0;
          if (len_full > payload_limit_r) begin
            discard_nxt = len_full;
            phase_nxt   = PH_DISCARD;
          end else if (len_full == 16'd0) begin
            phase_nxt         = PH_HUNT1;
            res_nxt.event_res = EV_EMPTY;
          end else begin
            phase_nxt = PH_PAYLOAD;
          end
        end
        PH_PAYLOAD: begin
          res_nxt.data_byte   = in_rx_byte;
          res_nxt.byte_offset = count_r;
          count_nxt           = count_inc;
          if (count_inc == length_r) begin
            phase_nxt         = PH_HUNT1;
            res_nxt.event_res = EV_LAST;
          end else begin
            res_nxt.event_res = EV_BYTE;
          end
        end
        default: begin
          // discard, also the unused phase code
          discard_nxt = discard_dec;
          if (discard_dec == 16'd0) begin
            phase_nxt         = PH_HUNT1;
            res_nxt.event_res = EV_OVERSIZE;
          end
        end
      endcase
    end

    res_nxt.frame_type   = kind_nxt;
    res_nxt.frame_length = length_nxt;
    res_nxt.busy_res     = (phase_nxt != PH_HUNT1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sync_first_r    <= '0;
      sync_second_r   <= '0;
      payload_limit_r <= PAYLOAD_LIMIT_RST;
      phase_r         <= PH_HUNT1;
      kind_r          <= '0;
      length_r        <= '0;
      count_r         <= '0;
      discard_r       <= '0;
      out_valid_r     <= 1'b0;
      skid_valid_r    <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_SYNC_FIRST:    sync_first_r    <= cfg_wdata[7:0];
          REG_SYNC_SECOND:   sync_second_r   <= cfg_wdata[7:0];
          REG_PAYLOAD_LIMIT: payload_limit_r <= cfg_wdata;
          default: ;
        endcase
      end

      if (in_accept) begin
        phase_r   <= phase_nxt;
        kind_r    <= kind_nxt;
        length_r  <= length_nxt;
        count_r   <= count_nxt;
        discard_r <= discard_nxt;
      end

      // output register with one-entry skid behind it
      if (skid_valid_r) begin
        if (out_take) begin
          out_r        <= skid_r;
          skid_valid_r <= 1'b0;
        end
      end else if (in_accept) begin
        if (!out_valid_r || out_take) begin
          out_r       <= res_nxt;
          out_valid_r <= 1'b1;
        end else begin
          skid_r       <= res_nxt;
          skid_valid_r <= 1'b1;
        end
      end else if (out_take) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid        = out_valid_r;
  assign out_event_res    = out_r.event_res;
  assign out_frame_type   = out_r.frame_type;
  assign out_frame_length = out_r.frame_length;
  assign out_data_byte    = out_r.data_byte;
  assign out_byte_offset  = out_r.byte_offset;
  assign out_busy_res     = out_r.busy_res;

  // skid only fills behind a held output beat
  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid holds a beat while output register is empty");

  // a stalled result beat is never dropped
  a_out_held: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_stall) |=> out_valid_r)
    else $error("stalled result beat lost");

  // in payload the length is non-zero and the count has not yet reached it
  a_payload_count: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_PAYLOAD) |-> (length_r != 16'd0 && count_r < length_r))
    else $error("payload count out of range");

  // a reset command returns to sync hunt
  a_cmd_reset: assert property (@(posedge clk) disable iff (!rst_n)
    (in_accept && in_command == CMD_RESET) |=> (phase_r == PH_HUNT1 && length_r == 16'd0))
    else $error("reset command did not restart the hunt");

endmodule

// ===== verif/tb.sv =====
// Self-checking testbench for the sync/length-prefixed byte deframer.
module tb
  import sld_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 4_000_000;  // far above the slowest correct run
  localparam int HOLD_CYCLES = 300;        // long receiver hold-off
  localparam int REPORT_CAP  = 200;        // mismatches beyond this are only counted

  // Header/payload position of the deframer, as tracked by the predictor
  typedef enum logic [2:0] {
    PH_SYNC1, PH_SYNC2, PH_TYPE, PH_LEN_LO, PH_LEN_HI, PH_DATA, PH_DROP
  } deframe_phase_t;

  // One beat on the input channel
  typedef struct packed {
    logic       cmd;
    logic [7:0] rx;
  } rx_beat_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic        in_valid = 1'b0;
  logic        in_stall;
  logic        in_command = CMD_RX;
  logic [7:0]  in_rx_byte = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [2:0]  out_event_res;
  logic [7:0]  out_frame_type;
  logic [15:0] out_frame_length;
  logic [7:0]  out_data_byte;
  logic [15:0] out_byte_offset;
  logic        out_busy_res;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = REG_SYNC_FIRST;
  logic [15:0] cfg_wdata = '0;

  // Stimulus waiting for the driver, and predicted result beats not yet seen
  rx_beat_t tx_q[$];
  res_t     results_due[$];

  // Mirror of the configuration registers
  logic [7:0]  m_sync_a = 8'h00;
  logic [7:0]  m_sync_b = 8'h00;
  logic [15:0] m_limit  = PAYLOAD_LIMIT_RST;

  // Mirror of the frame state
  deframe_phase_t m_phase = PH_SYNC1;
  logic [7:0]     m_type  = 8'h00;
  logic [15:0]    m_len   = 16'h0000;
  logic [15:0]    m_count = 16'h0000;
  logic [15:0]    m_left  = 16'h0000;

  int mismatches = 0;
  int cycles = 0;

  // Sender pacing
  int burst_left = 0;
  int gap_left = 0;

  // Receiver pacing; holds_asked is bumped by the stimulus to request a long hold-off
  int unsigned holds_asked = 0;
  int unsigned holds_served = 0;
  int hold_left = 0;
  int mode_left = 0;
  int stall_mode = 0;

  sync_length_deframer uut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_command       (in_command),
    .in_rx_byte       (in_rx_byte),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_event_res    (out_event_res),
    .out_frame_type   (out_frame_type),
    .out_frame_length (out_frame_length),
    .out_data_byte    (out_data_byte),
    .out_byte_offset  (out_byte_offset),
    .out_busy_res     (out_busy_res),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata)
  );

  always #6 clk = ~clk;

  // Advance the frame state by one input beat and return the result beat it yields.
  function automatic res_t deframe_beat(logic cmd, logic [7:0] b);
    res_t r;
    r = '0;
    r.event_res = EV_NONE;
    if (cmd == CMD_RESET) begin
      // session reset keeps the type latch, clears the rest
      m_phase = PH_SYNC1;
      m_len   = '0;
      m_count = '0;
      m_left  = '0;
    end else begin
      case (m_phase)
        PH_SYNC1: begin
          if (b == m_sync_a) m_phase = PH_SYNC2;
        end
        PH_SYNC2: begin
          // a repeated first sync byte keeps the partial match
          if (b == m_sync_b) m_phase = PH_TYPE;
          else if (b == m_sync_a) m_phase = PH_SYNC2;
          else m_phase = PH_SYNC1;
        end
        PH_TYPE: begin
          m_type  = b;
          m_phase = PH_LEN_LO;
        end
        PH_LEN_LO: begin
          m_len   = {8'h00, b};
          m_phase = PH_LEN_HI;
        end
        PH_LEN_HI: begin
          m_len[15:8] = b;
          m_count     = '0;
          if (m_len > m_limit) begin
            m_left  = m_len;
            m_phase = PH_DROP;
          end else if (m_len == 16'h0000) begin
            m_phase     = PH_SYNC1;
            r.event_res = EV_EMPTY;
          end else begin
            m_phase = PH_DATA;
          end
        end
        PH_DATA: begin
          r.data_byte   = b;
          r.byte_offset = m_count;
          m_count       = m_count + 16'd1;
          if (m_count == m_len) begin
            m_phase     = PH_SYNC1;
            r.event_res = EV_LAST;
          end else begin
            r.event_res = EV_BYTE;
          end
        end
        default: begin
          // oversize: swallow the declared bytes, report on the last one
          if (m_left != 16'h0000) m_left = m_left - 16'd1;
          if (m_left == 16'h0000) begin
            m_phase     = PH_SYNC1;
            r.event_res = EV_OVERSIZE;
          end
        end
      endcase
    end
    r.frame_type   = m_type;
    r.frame_length = m_len;
    r.busy_res     = (m_phase != PH_SYNC1);
    return r;
  endfunction

  function automatic void check_field(string name, logic [15:0] want, logic [15:0] got);
    if (want !== got) begin
      mismatches++;
      if (mismatches <= REPORT_CAP)
        $error("%s: expected %0d, got %0d", name, want, got);
    end
  endfunction

  function automatic void push_rx(logic [7:0] b);
    tx_q.push_back('{cmd: CMD_RX, rx: b});
  endfunction

  function automatic void push_reset(logic [7:0] b);
    tx_q.push_back('{cmd: CMD_RESET, rx: b});
  endfunction

  // Queue one chunk of traffic: mostly well-formed frames with random content,
  // some cut short by a session reset, plus line noise and lone resets.
  // Returns the number of beats that count towards the stimulus budget.
  function automatic int queue_frame();
    int pick, len, cut, lim, i;
    logic [15:0] len16;
    bit broken;
    pick = $urandom_range(0, 99);
    lim  = int'(m_limit);
    if (pick < 8) begin
      // noise while hunting: ignored bytes, not counted
      repeat ($urandom_range(1, 6)) push_rx(8'($urandom_range(0, 255)));
      return 0;
    end
    if (pick < 12) begin
      push_reset(8'($urandom_range(0, 255)));
      return 1;
    end
    broken = (pick < 24);
    repeat ($urandom_range(0, 2)) push_rx(8'($urandom_range(0, 255)));
    push_rx(m_sync_a);
    if ($urandom_range(0, 5) == 0) push_rx(m_sync_a);
    push_rx(m_sync_b);
    push_rx(8'($urandom_range(0, 255)));
    // lengths stay small; oversize only where the limit keeps the discard short
    if ($urandom_range(0, 9) == 0) len = 0;
    else if ($urandom_range(0, 4) == 0 && lim <= 64) len = lim + $urandom_range(1, 12);
    else if (lim == 0) len = $urandom_range(1, 12);
    else len = $urandom_range(1, (lim < 24) ? lim : 24);
    len16 = len[15:0];
    push_rx(len16[7:0]);
    push_rx(len16[15:8]);
    cut = (broken && len > 0) ? $urandom_range(0, len - 1) : len;
    for (i = 0; i < len; i++) begin
      if (i == cut) begin
        push_reset(8'($urandom_range(0, 255)));
        break;
      end
      push_rx(8'($urandom_range(0, 255)));
    end
    return len + 5;
  endfunction

  task automatic feed_random(int target);
    int counted;
    counted = 0;
    while (counted < target) counted += queue_frame();
  endtask

  // Register write; callers must issue it only while the deframer is idle; the task does not enforce it.
  task automatic write_reg(logic [1:0] idx, logic [15:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      REG_SYNC_FIRST:    m_sync_a = val[7:0];
      REG_SYNC_SECOND:   m_sync_b = val[7:0];
      REG_PAYLOAD_LIMIT: m_limit  = val;
      default: ;
    endcase
  endtask

  task automatic write_all(logic [15:0] sync_a, logic [15:0] sync_b, logic [15:0] limit);
    write_reg(REG_SYNC_FIRST, sync_a);
    write_reg(REG_SYNC_SECOND, sync_b);
    write_reg(REG_PAYLOAD_LIMIT, limit);
  endtask

  // Wait for the sender to run dry and every predicted beat to come back.
  task automatic settle();
    do @(posedge clk); while (tx_q.size() != 0 || in_valid || results_due.size() != 0);
    repeat (4) @(posedge clk);
  endtask

  // Driver: presents queued beats in bursts separated by random gaps.
  // A stalled beat is held unchanged; prediction happens at the accepting edge.
  always @(posedge clk) begin
    rx_beat_t nxt;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall)
        results_due.push_back(deframe_beat(in_command, in_rx_byte));
      if (!in_valid || !in_stall) begin
        if (gap_left != 0 || tx_q.size() == 0) begin
          if (gap_left != 0) gap_left--;
          in_valid <= 1'b0;
        end else begin
          nxt = tx_q.pop_front();
          in_valid   <= 1'b1;
          in_command <= nxt.cmd;
          in_rx_byte <= nxt.rx;
          if (burst_left <= 1) begin
            burst_left = $urandom_range(1, 40);
            // a quarter of bursts run straight into the next one
            gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
          end else begin
            burst_left--;
          end
        end
      end
    end
  end

  // Receiver back-pressure: a long hold-off on request, otherwise a mode
  // picked at random and held for a random span (free, light, heavy, periodic).
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else if (holds_served != holds_asked) begin
      holds_served++;
      hold_left = HOLD_CYCLES;
      out_stall <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      if (mode_left == 0) begin
        stall_mode = $urandom_range(0, 3);
        mode_left  = $urandom_range(32, 256);
      end else begin
        mode_left--;
      end
      case (stall_mode)
        0:       out_stall <= 1'b0;
        1:       out_stall <= ($urandom_range(0, 3) == 0);
        2:       out_stall <= ($urandom_range(0, 3) != 0);
        default: out_stall <= cycles[2];
      endcase
    end
  end

  // Monitor: each accepted result beat is checked against the oldest prediction.
  always @(posedge clk) begin
    res_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (results_due.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_CAP)
          $error("result beat with nothing predicted: event_res %0d", out_event_res);
      end else begin
        want = results_due.pop_front();
        check_field("event_res",    16'(want.event_res),    16'(out_event_res));
        check_field("frame_type",   16'(want.frame_type),   16'(out_frame_type));
        check_field("frame_length", want.frame_length,      out_frame_length);
        check_field("data_byte",    16'(want.data_byte),    16'(out_data_byte));
        check_field("byte_offset",  want.byte_offset,       out_byte_offset);
        check_field("busy_res",     16'(want.busy_res),     16'(out_busy_res));
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  initial begin
    logic [7:0] hand_bytes[$];
    int i;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // Registers at their reset values: both sync bytes zero, limit 1024
    feed_random(150);
    settle();

    // Hand-picked frames, limit 2: noise then a repeated first sync byte,
    // a two-byte payload at the byte extremes, an empty frame, an oversize
    // frame swallowed whole, and a session reset straight after a type byte
    write_all(16'h00A5, 16'h005A, 16'd2);
    hand_bytes = '{8'h33, 8'hA5, 8'hA5, 8'h5A, 8'hFF, 8'h02, 8'h00, 8'h00, 8'hFF,
                   8'hA5, 8'h5A, 8'h00, 8'h00, 8'h00,
                   8'hA5, 8'h5A, 8'h7E, 8'h03, 8'h00, 8'h12, 8'hED, 8'h80,
                   8'hA5, 8'h5A, 8'h11};
    foreach (hand_bytes[k]) push_rx(hand_bytes[k]);
    push_reset(8'hFF);
    settle();

    // Limit zero: every non-empty frame is oversize; junk in the unused upper bits
    write_all(16'hC3FF, 16'h5A00, 16'd0);
    feed_random(150);
    settle();

    // Limit at its top: a 257-byte frame whose length uses the high byte
    write_all(16'h0000, 16'h00FF, 16'hFFFF);
    push_reset(8'h00);
    push_rx(8'h00);
    push_rx(8'hFF);
    push_rx(8'($urandom_range(0, 255)));
    push_rx(8'h01);
    push_rx(8'h01);
    for (i = 0; i < 257; i++) push_rx(8'($urandom_range(0, 255)));
    settle();

    // Equal sync bytes; receiver holds off while the sender keeps offering
    write_all(16'h007E, 16'h007E, 16'd16);
    feed_random(300);
    holds_asked++;
    settle();

    // Random sync bytes with small limits
    repeat (3) begin
      write_all(16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)),
                16'($urandom_range(0, 40)));
      feed_random(120);
      settle();
    end

    // Random sync bytes with a larger limit, and a second long hold-off
    write_all(16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)),
              16'($urandom_range(41, 600)));
    feed_random(200);
    holds_asked++;
    settle();

    repeat (8) @(posedge clk);
    if (mismatches == 0 && results_due.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
